// ----- hdl/hsb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsb_pkg
// shared types and constants of the hue/saturation/brightness to rgb pipeline
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int unsigned CHAN_W = 8;

  localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'd255;
  localparam logic [2:0] SECTORS = 3'd6;
  localparam int unsigned SCALED_W = CHAN_W + 3;

  typedef enum logic [2:0] {
    SECTOR_RED_GREEN  = 3'd0,
    SECTOR_GREEN_RED  = 3'd1,
    SECTOR_GREEN_BLUE = 3'd2,
    SECTOR_BLUE_GREEN = 3'd3,
    SECTOR_BLUE_RED   = 3'd4,
    SECTOR_RED_BLUE   = 3'd5
  } sector_t;

  // after sector split
  typedef struct packed {
    sector_t           sector;
    logic [CHAN_W-1:0] frac;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
    logic              grey;
  } split_t;

  // after first products
  typedef struct packed {
    sector_t           sector;
    logic [CHAN_W-1:0] val;
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] sf;
    logic [CHAN_W-1:0] sfi;
    logic              grey;
  } part_t;

  // all levels ready for routing
  typedef struct packed {
    sector_t           sector;
    logic [CHAN_W-1:0] val;
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] t;
    logic              grey;
  } level_t;

endpackage

// ----- hdl/hsb_if.sv -----
// ----------------------------------------------------------------------------
// hsb_in_if / hsb_out_if
// valid/ready channels for hsb color items and rgb result items
// ----------------------------------------------------------------------------
interface hsb_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsb_pkg::CHAN_W-1:0]    hue;
  logic [hsb_pkg::CHAN_W-1:0]    saturation;
  logic [hsb_pkg::CHAN_W-1:0]    brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

interface hsb_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsb_pkg::CHAN_W-1:0]    red;
  logic [hsb_pkg::CHAN_W-1:0]    green;
  logic [hsb_pkg::CHAN_W-1:0]    blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hsb_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter
// pipelined 8-bit hue/saturation/brightness to 8-bit rgb conversion
// ----------------------------------------------------------------------------
// an accepted item passes the split, product, level and output registers before result valid
// throughput: one item per cycle, set by one product per path per stage
// stalls hold every stage in place; nothing is dropped or repeated
// reset clears the stage valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter (
  input  logic       clk,
  input  logic       rst,
  hsb_in_if.sink     pixel_in,
  hsb_out_if.source  pixel_out
);

  hsb_pkg::split_t split_data;
  logic            split_valid;
  logic            split_ready;

  hsb_pkg::level_t lvl;
  logic            lvl_valid;
  logic            lvl_ready;

  logic [hsb_pkg::CHAN_W-1:0] red_next;
  logic [hsb_pkg::CHAN_W-1:0] green_next;
  logic [hsb_pkg::CHAN_W-1:0] blue_next;

  hsb_split u_split (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_in),
    .valid    (split_valid),
    .ready    (split_ready),
    .data     (split_data)
  );

  hsb_levels u_levels (
    .clk      (clk),
    .rst      (rst),
    .in_valid (split_valid),
    .in_ready (split_ready),
    .in_data  (split_data),
    .valid    (lvl_valid),
    .ready    (lvl_ready),
    .data     (lvl)
  );

  assign lvl_ready = !pixel_out.valid || pixel_out.ready;

  // sector routing
  always_comb begin
    red_next   = lvl.val;
    green_next = lvl.val;
    blue_next  = lvl.val;
    if (!lvl.grey) begin
      case (lvl.sector)
        hsb_pkg::SECTOR_RED_GREEN: begin
          red_next = lvl.val; green_next = lvl.t;   blue_next = lvl.p;
        end
        hsb_pkg::SECTOR_GREEN_RED: begin
          red_next = lvl.q;   green_next = lvl.val; blue_next = lvl.p;
        end
        hsb_pkg::SECTOR_GREEN_BLUE: begin
          red_next = lvl.p;   green_next = lvl.val; blue_next = lvl.t;
        end
        hsb_pkg::SECTOR_BLUE_GREEN: begin
          red_next = lvl.p;   green_next = lvl.q;   blue_next = lvl.val;
        end
        hsb_pkg::SECTOR_BLUE_RED: begin
          red_next = lvl.t;   green_next = lvl.p;   blue_next = lvl.val;
        end
        default: begin
          red_next = lvl.val; green_next = lvl.p;   blue_next = lvl.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (lvl_ready) begin
      pixel_out.valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready && lvl_valid) begin
      pixel_out.red   <= red_next;
      pixel_out.green <= green_next;
      pixel_out.blue  <= blue_next;
    end
  end

endmodule

// ----- hdl/hsb_split.sv -----
// ----------------------------------------------------------------------------
// hsb_split
// first stage: hue times six, split into sector and offset
// ----------------------------------------------------------------------------
module hsb_split (
  input  logic            clk,
  input  logic            rst,
  hsb_in_if.sink          pixel_in,
  output logic            valid,
  input  logic            ready,
  output hsb_pkg::split_t data
);

  logic [hsb_pkg::SCALED_W-1:0] scaled;
  logic                         advance;

  assign advance = !valid || ready;
  assign pixel_in.ready = advance;
  assign scaled = hsb_pkg::SCALED_W'(pixel_in.hue)
                * hsb_pkg::SCALED_W'(hsb_pkg::SECTORS);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pixel_in.valid) begin
      data.sector <= hsb_pkg::sector_t'(scaled[hsb_pkg::SCALED_W-1:hsb_pkg::CHAN_W]);
      data.frac   <= scaled[hsb_pkg::CHAN_W-1:0];
      data.sat    <= pixel_in.saturation;
      data.val    <= pixel_in.brightness;
      data.grey   <= (pixel_in.saturation == '0);
    end
  end

endmodule

// ----- hdl/hsb_levels.sv -----
// ----------------------------------------------------------------------------
// hsb_levels
// two product stages forming the p, q and t levels
// ----------------------------------------------------------------------------
module hsb_levels (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hsb_pkg::split_t in_data,
  output logic            valid,
  input  logic            ready,
  output hsb_pkg::level_t data
);

  localparam int unsigned W = hsb_pkg::CHAN_W;

  hsb_pkg::part_t mid;
  logic           mid_valid;
  logic           mid_ready;

  logic [2*W-1:0] prod_p;
  logic [2*W-1:0] prod_sf;
  logic [2*W-1:0] prod_sfi;
  logic [2*W-1:0] prod_q;
  logic [2*W-1:0] prod_t;

  assign in_ready  = !mid_valid || mid_ready;
  assign mid_ready = !valid || ready;

  assign prod_p   = (2*W)'(in_data.val) * (2*W)'(hsb_pkg::FULL_LEVEL - in_data.sat);
  assign prod_sf  = (2*W)'(in_data.sat) * (2*W)'(in_data.frac);
  assign prod_sfi = (2*W)'(in_data.sat) * (2*W)'(hsb_pkg::FULL_LEVEL - in_data.frac);

  assign prod_q = (2*W)'(mid.val) * (2*W)'(hsb_pkg::FULL_LEVEL - mid.sf);
  assign prod_t = (2*W)'(mid.val) * (2*W)'(hsb_pkg::FULL_LEVEL - mid.sfi);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid.sector <= in_data.sector;
      mid.val    <= in_data.val;
      mid.grey   <= in_data.grey;
      mid.p      <= prod_p[2*W-1:W];
      mid.sf     <= prod_sf[2*W-1:W];
      mid.sfi    <= prod_sfi[2*W-1:W];
    end
    if (mid_ready && mid_valid) begin
      data.sector <= mid.sector;
      data.val    <= mid.val;
      data.grey   <= mid.grey;
      data.p      <= mid.p;
      data.q      <= prod_q[2*W-1:W];
      data.t      <= prod_t[2*W-1:W];
    end
  end

endmodule

// ----- test/hsb_to_rgb_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter_tb
// self-checking bench for the hsb to rgb converter: directed corner colors,
// then random bursts with sender gaps and receiver stalls; every accepted
// color is converted by an independent predictor and results are compared
// in order, channel by channel
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [hsb_pkg::CHAN_W-1:0] red;
  logic [hsb_pkg::CHAN_W-1:0] green;
  logic [hsb_pkg::CHAN_W-1:0] blue;
} rgb_t;

class rgb_scoreboard;
  rgb_t        pending_rgb[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  static function rgb_t hsb_to_rgb(input logic [hsb_pkg::CHAN_W-1:0] hue, sat, bri);
    logic [hsb_pkg::SCALED_W-1:0] scaled;
    logic [hsb_pkg::CHAN_W-1:0]   frac, p, q, t, sf, sfi;
    logic [2*hsb_pkg::CHAN_W-1:0] prod;
    hsb_pkg::sector_t             sector;
    rgb_t                         rgb;
    if (sat == '0) begin
      rgb.red   = bri;
      rgb.green = bri;
      rgb.blue  = bri;
      return rgb;
    end
    scaled = hsb_pkg::SCALED_W'(hue) * hsb_pkg::SCALED_W'(hsb_pkg::SECTORS);
    sector = hsb_pkg::sector_t'(scaled[hsb_pkg::SCALED_W-1:hsb_pkg::CHAN_W]);
    frac   = scaled[hsb_pkg::CHAN_W-1:0];
    prod   = (2*hsb_pkg::CHAN_W)'(bri) * (2*hsb_pkg::CHAN_W)'(hsb_pkg::FULL_LEVEL - sat);
    p      = prod[2*hsb_pkg::CHAN_W-1:hsb_pkg::CHAN_W];
    prod   = (2*hsb_pkg::CHAN_W)'(sat) * (2*hsb_pkg::CHAN_W)'(frac);
    sf     = prod[2*hsb_pkg::CHAN_W-1:hsb_pkg::CHAN_W];
    prod   = (2*hsb_pkg::CHAN_W)'(sat) * (2*hsb_pkg::CHAN_W)'(hsb_pkg::FULL_LEVEL - frac);
    sfi    = prod[2*hsb_pkg::CHAN_W-1:hsb_pkg::CHAN_W];
    prod   = (2*hsb_pkg::CHAN_W)'(bri) * (2*hsb_pkg::CHAN_W)'(hsb_pkg::FULL_LEVEL - sf);
    q      = prod[2*hsb_pkg::CHAN_W-1:hsb_pkg::CHAN_W];
    prod   = (2*hsb_pkg::CHAN_W)'(bri) * (2*hsb_pkg::CHAN_W)'(hsb_pkg::FULL_LEVEL - sfi);
    t      = prod[2*hsb_pkg::CHAN_W-1:hsb_pkg::CHAN_W];
    case (sector)
      hsb_pkg::SECTOR_RED_GREEN: begin
        rgb = {bri, t, p};
      end
      hsb_pkg::SECTOR_GREEN_RED: begin
        rgb = {q, bri, p};
      end
      hsb_pkg::SECTOR_GREEN_BLUE: begin
        rgb = {p, bri, t};
      end
      hsb_pkg::SECTOR_BLUE_GREEN: begin
        rgb = {p, q, bri};
      end
      hsb_pkg::SECTOR_BLUE_RED: begin
        rgb = {t, p, bri};
      end
      default: begin
        rgb = {bri, p, q};
      end
    endcase
    return rgb;
  endfunction

  function void note_colour(input logic [hsb_pkg::CHAN_W-1:0] hue, sat, bri);
    pending_rgb.push_back(hsb_to_rgb(hue, sat, bri));
  endfunction

  function int unsigned pending();
    return pending_rgb.size();
  endfunction

  task report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  task check_rgb(input logic [hsb_pkg::CHAN_W-1:0] red, green, blue);
    rgb_t want;
    if (pending_rgb.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d/%0d with no color pending",
                                red, green, blue));
      return;
    end
    want = pending_rgb.pop_front();
    if (red !== want.red)
      report_mismatch($sformatf("red got %0d want %0d", red, want.red));
    if (green !== want.green)
      report_mismatch($sformatf("green got %0d want %0d", green, want.green));
    if (blue !== want.blue)
      report_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
  endtask
endclass

module hsb_to_rgb_converter_tb;

  localparam int unsigned RANDOM_ITEMS = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsb_in_if  pixel_in ();
  hsb_out_if pixel_out ();

  rgb_scoreboard colour_sb = new();

  hsb_to_rgb_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in.sink),
    .pixel_out (pixel_out.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && pixel_in.valid === 1'b1 && pixel_in.ready === 1'b1)
      colour_sb.note_colour(pixel_in.hue, pixel_in.saturation, pixel_in.brightness);
    if (!rst && pixel_out.valid === 1'b1 && pixel_out.ready === 1'b1)
      colour_sb.check_rgb(pixel_out.red, pixel_out.green, pixel_out.blue);
  end

  // receiver: stretches of full rate, stalls and per-cycle flicker
  initial begin
    int unsigned kind, len;
    pixel_out.ready <= 1'b0;
    forever begin
      kind = $urandom_range(0, 3);
      len  = (kind == 0) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        case (kind)
          0: pixel_out.ready <= 1'b0;
          1: pixel_out.ready <= 1'($urandom_range(0, 1));
          default: pixel_out.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_colour(input logic [hsb_pkg::CHAN_W-1:0] hue, sat, bri);
    pixel_in.valid      <= 1'b1;
    pixel_in.hue        <= hue;
    pixel_in.saturation <= sat;
    pixel_in.brightness <= bri;
    @(posedge clk);
    while (pixel_in.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles == 0) return;
    pixel_in.valid      <= 1'b0;
    pixel_in.hue        <= hsb_pkg::CHAN_W'($urandom);
    pixel_in.saturation <= hsb_pkg::CHAN_W'($urandom);
    pixel_in.brightness <= hsb_pkg::CHAN_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    pixel_in.valid <= 1'b0;
    @(posedge clk);
    while (colour_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_colour();
    logic [hsb_pkg::CHAN_W-1:0] sat, bri;
    case ($urandom_range(0, 9))
      0: sat = '0;
      1: sat = hsb_pkg::FULL_LEVEL;
      default: sat = hsb_pkg::CHAN_W'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0: bri = '0;
      1: bri = hsb_pkg::FULL_LEVEL;
      default: bri = hsb_pkg::CHAN_W'($urandom);
    endcase
    send_colour(hsb_pkg::CHAN_W'($urandom), sat, bri);
  endtask

  initial begin
    int unsigned sent, burst;
    pixel_in.valid      <= 1'b0;
    pixel_in.hue        <= '0;
    pixel_in.saturation <= '0;
    pixel_in.brightness <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // gray, black and white
    send_colour(8'd0, 8'd0, 8'd0);
    send_colour(8'd0, 8'd0, 8'd255);
    send_colour(8'd137, 8'd0, 8'd200);
    send_colour(8'd255, 8'd0, 8'd255);
    // sector edges and full saturation
    send_colour(8'd0, 8'd255, 8'd255);
    send_colour(8'd42, 8'd255, 8'd255);
    send_colour(8'd43, 8'd200, 8'd255);
    send_colour(8'd85, 8'd255, 8'd128);
    send_colour(8'd86, 8'd255, 8'd255);
    send_colour(8'd128, 8'd255, 8'd255);
    send_colour(8'd170, 8'd128, 8'd77);
    send_colour(8'd171, 8'd255, 8'd255);
    send_colour(8'd213, 8'd255, 8'd255);
    send_colour(8'd214, 8'd255, 8'd255);
    send_colour(8'd255, 8'd255, 8'd255);
    // smallest saturation and brightness, then other mixed colors
    send_colour(8'd255, 8'd1, 8'd255);
    send_colour(8'd0, 8'd1, 8'd1);
    send_colour(8'd100, 8'd255, 8'd0);
    send_colour(8'd200, 8'd128, 8'd255);
    send_colour(8'd64, 8'd255, 8'd255);
    send_colour(8'd21, 8'd170, 8'd201);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 30);
      for (int unsigned i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_colour();
        sent++;
      end
      if ($urandom_range(0, 15) == 0)
        drain_results();
      else if ($urandom_range(0, 3) == 0)
        pause_sender($urandom_range(5, 20));
      else
        pause_sender($urandom_range(0, 3));
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (colour_sb.errors == 0 && colour_sb.pending() == 0) begin
      $display("hsb_to_rgb_converter_tb: PASS");
    end else begin
      $display("hsb_to_rgb_converter_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("hsb_to_rgb_converter_tb: FAIL");
    $finish;
  end

endmodule
